// ===== src/vs_pkg.sv =====
// shared constants and types for the cosine top-k vector search block
`timescale 1ns / 1ps
`default_nettype none
package vs_pkg;

  localparam int MAX_DOCS_DEF   = 128;
  localparam int VEC_LEN_DEF    = 256;
  localparam int MAX_TOP_K_DEF  = 8;

  // request codes
  localparam logic [1:0] REQ_DOC   = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // result status codes
  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_RESULT  = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  localparam logic signed [15:0] SCORE_MIN = 16'sh8000;
  localparam logic signed [15:0] SCORE_MAX = 16'sh7fff;
  localparam logic [3:0]         TOP_K_RST = 4'd4;

  typedef struct packed {
    logic               done;
    logic signed [15:0] score;
  } score_res_t;

endpackage
`default_nettype wire

// ===== src/vs_if.sv =====
// item channel interfaces for requests and results
`timescale 1ns / 1ps
`default_nettype none
interface vs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [15:0] value;
  logic               last_element;

  modport source (output valid, req_type, value, last_element, input ready);
  modport sink (input valid, req_type, value, last_element, output ready);
endinterface

interface vs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [2:0]         rank;
  logic [6:0]         doc_index;
  logic               found;
  logic signed [15:0] match_score;
  logic               last;

  modport source (output valid, status, rank, doc_index, found, match_score, last,
                  input ready);
  modport sink (input valid, status, rank, doc_index, found, match_score, last,
                output ready);
endinterface
`default_nettype wire

// ===== src/vs_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module vs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/vs_score.sv =====
// cosine score engine: shared multiplier, iterative root and divider
`timescale 1ns / 1ps
`default_nettype none
module vs_score import vs_pkg::*; #(
  parameter int VEC_LEN = VEC_LEN_DEF,
  localparam int IW = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [15:0] q_i,
  input  wire logic signed [15:0] d_i,
  output logic [IW-1:0]           rd_idx_o,
  output score_res_t              res_o
);

  localparam int L   = $clog2(VEC_LEN);
  localparam int AW  = 32 + L;
  localparam int NWE = AW + (AW % 2);
  localparam int RW  = NWE / 2;
  localparam int MW  = (RW + 1 > 17) ? RW + 1 : 17;
  localparam int PW  = 2 * MW;
  localparam int DW  = 2 * RW;
  localparam logic [IW-1:0]  LAST_IDX = IW'(VEC_LEN - 1);
  localparam logic [NWE-1:0] TOP_BIT  = {2'b01, {(NWE-2){1'b0}}};
  localparam logic [3:0]     DIV_LAST = 4'd14;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ELEM  = 4'd1;
  localparam logic [3:0] S_DRAIN = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_SQ_Q  = 4'd4;
  localparam logic [3:0] S_SQ_D  = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_MULW  = 4'd7;
  localparam logic [3:0] S_DEN   = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  localparam logic [1:0] A_NONE = 2'd0;
  localparam logic [1:0] A_DOT  = 2'd1;
  localparam logic [1:0] A_NQ   = 2'd2;
  localparam logic [1:0] A_ND   = 2'd3;

  logic [3:0]            state_q, state_d;
  logic [1:0]            ph_q, ph_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [1:0]            acc_sel_q, acc_sel_d;
  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]  prod_d, prod_q;
  logic signed [AW-1:0]  dot_q;
  logic [AW-1:0]         nq_q, nd_q, abs_dot;
  logic [NWE-1:0]        x_q, r_q, bit_q, sq_sum;
  logic                  sq_ge;
  logic [RW-1:0]         sq_q, sd_q;
  logic [DW-1:0]         den_q;
  logic [DW:0]           rem_q, rem_sh;
  logic                  div_ge;
  logic [14:0]           qt_q, qt_nxt;
  logic [3:0]            cnt_q;
  logic signed [15:0]    score_q;

  // operand select for the one multiplier
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    acc_sel_d = A_NONE;
    if (state_q == S_ELEM) begin
      case (ph_q)
        2'd1: begin
          mul_a = MW'(q_i); mul_b = MW'(d_i); acc_sel_d = A_DOT;
        end
        2'd2: begin
          mul_a = MW'(q_i); mul_b = MW'(q_i); acc_sel_d = A_NQ;
        end
        2'd3: begin
          mul_a = MW'(d_i); mul_b = MW'(d_i); acc_sel_d = A_ND;
        end
        default: acc_sel_d = A_NONE;
      endcase
    end else if (state_q == S_MUL) begin
      mul_a = MW'(sq_q);
      mul_b = MW'(sd_q);
    end
  end

  assign prod_d  = PW'(mul_a) * PW'(mul_b);
  assign sq_sum  = r_q + bit_q;
  assign sq_ge   = (x_q >= sq_sum);
  assign abs_dot = dot_q[AW-1] ? AW'(-dot_q) : AW'(dot_q);
  assign rem_sh  = {rem_q[DW-1:0], 1'b0};
  assign div_ge  = (rem_sh >= {1'b0, den_q});
  assign qt_nxt  = {qt_q[13:0], div_ge};

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    idx_d   = idx_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_ELEM;
          ph_d    = 2'd0;
          idx_d   = '0;
        end
      end
      S_ELEM: begin
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd3) begin
          if (idx_q == LAST_IDX) begin
            state_d = S_DRAIN;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      S_DRAIN: state_d = S_CHK;
      S_CHK:   state_d = ((nq_q == '0) || (nd_q == '0)) ? S_DONE : S_SQ_Q;
      S_SQ_Q:  if (bit_q == '0) state_d = S_SQ_D;
      S_SQ_D:  if (bit_q == '0) state_d = S_MUL;
      S_MUL:   state_d = S_MULW;
      S_MULW:  state_d = S_DEN;
      S_DEN:   state_d = (DW'(abs_dot) >= den_q) ? S_DONE : S_DIV;
      S_DIV:   if (cnt_q == DIV_LAST) state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ph_q      <= 2'd0;
      idx_q     <= '0;
      acc_sel_q <= A_NONE;
    end else begin
      state_q   <= state_d;
      ph_q      <= ph_d;
      idx_q     <= idx_d;
      acc_sel_q <= acc_sel_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (state_q == S_IDLE && start_i) begin
      dot_q <= '0;
      nq_q  <= '0;
      nd_q  <= '0;
    end else begin
      case (acc_sel_q)
        A_DOT:   dot_q <= dot_q + prod_q[AW-1:0];
        A_NQ:    nq_q  <= nq_q + prod_q[AW-1:0];
        A_ND:    nd_q  <= nd_q + prod_q[AW-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_CHK: begin
        score_q <= '0;
        x_q     <= NWE'(nq_q);
        r_q     <= '0;
        bit_q   <= TOP_BIT;
      end
      S_SQ_Q, S_SQ_D: begin
        if (bit_q == '0) begin
          if (state_q == S_SQ_Q) begin
            sq_q  <= r_q[RW-1:0];
            x_q   <= NWE'(nd_q);
            r_q   <= '0;
            bit_q <= TOP_BIT;
          end else begin
            sd_q <= r_q[RW-1:0];
          end
        end else begin
          if (sq_ge) begin
            x_q <= x_q - sq_sum;
            r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
      end
      S_MULW: den_q <= prod_q[DW-1:0];
      S_DEN: begin
        score_q <= dot_q[AW-1] ? SCORE_MIN : SCORE_MAX;
        rem_q   <= (DW+1)'(abs_dot);
        qt_q    <= '0;
        cnt_q   <= '0;
      end
      S_DIV: begin
        rem_q <= div_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
        qt_q  <= qt_nxt;
        cnt_q <= cnt_q + 4'd1;
        score_q <= dot_q[AW-1] ? -$signed({1'b0, qt_nxt}) : $signed({1'b0, qt_nxt});
      end
      default: ;
    endcase
  end

  assign rd_idx_o    = idx_q;
  assign res_o.done  = (state_q == S_DONE);
  assign res_o.score = score_q;

endmodule
`default_nettype wire

// ===== src/cosine_topk_vector_search.sv =====
// top level of the cosine similarity top-k vector search block
// a final element first zero-fills the unsent positions (one a cycle), except in a
//   document for a full store; a store, full or clear reply waits in T_RES for a
//   free output register. a query scores each document in turn, cut short on a zero
//   norm or saturated score, then gives top_k results, one a cycle unless stalled.
// throughput: one element a cycle while a vector streams; input is held off while
//   filling, scoring or reporting. reset clears counts, list and sets top_k to 4
`timescale 1ns / 1ps
`default_nettype none
module cosine_topk_vector_search import vs_pkg::*; #(
  parameter int MAX_DOCS   = MAX_DOCS_DEF,
  parameter int VEC_LEN    = VEC_LEN_DEF,
  parameter int MAX_TOP_K  = MAX_TOP_K_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vs_in_if.sink      in_i,
  vs_out_if.source   res_o,
  input  wire logic       top_k_we_i,
  input  wire logic [3:0] top_k_i
);

  localparam int IW   = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;
  localparam int PPW  = $clog2(VEC_LEN + 1);
  localparam int DAW  = $clog2(MAX_DOCS * VEC_LEN);
  localparam int DCW  = $clog2(MAX_DOCS + 1);
  localparam int DIW  = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
  localparam int KW   = $clog2(MAX_TOP_K + 1);
  localparam int KIW  = (MAX_TOP_K > 1) ? $clog2(MAX_TOP_K) : 1;

  localparam logic [2:0] T_IDLE  = 3'd0;
  localparam logic [2:0] T_FILL  = 3'd1;
  localparam logic [2:0] T_RES   = 3'd2;
  localparam logic [2:0] T_QINIT = 3'd3;
  localparam logic [2:0] T_START = 3'd4;
  localparam logic [2:0] T_WAIT  = 3'd5;
  localparam logic [2:0] T_EMIT  = 3'd6;

  logic [2:0]     state_q;
  logic [PPW-1:0] pos_q, pos_eff, pos_nxt;
  logic           kind_q;      // vector in progress is a query
  logic [DCW-1:0] doc_cnt_q, doc_q;
  logic [DAW-1:0] wbase_q, rbase_q;
  logic [1:0]     res_status_q;
  logic [6:0]     res_idx_q;
  logic [3:0]     top_k_q;
  logic [KW-1:0]  k_q, k_clamp;
  logic [KIW-1:0] emit_q;

  logic signed [15:0] best_score_q [MAX_TOP_K];
  logic [DIW-1:0]     best_idx_q   [MAX_TOP_K];
  logic               best_val_q   [MAX_TOP_K];
  logic [MAX_TOP_K-1:0] gt;

  // output register
  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [2:0]         out_rank_q;
  logic [6:0]         out_idx_q;
  logic               out_found_q;
  logic signed [15:0] out_score_q;
  logic               out_last_q;
  logic               out_free;
  logic               out_load;

  // handshake and element bookkeeping
  logic acc, is_elem, is_query, full_now, in_range, need_fill, fill_end, emit_last;

  // rams and scorer
  logic               qram_we, dram_we;
  logic [IW-1:0]      qram_waddr, rd_idx;
  logic [DAW-1:0]     dram_waddr, dram_raddr;
  logic [15:0]        ram_wdata, q_rdata, d_rdata;
  score_res_t         sc_res;
  logic               sc_start;

  assign in_i.ready = (state_q == T_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign is_elem    = (in_i.req_type == REQ_DOC) || (in_i.req_type == REQ_QUERY);
  assign is_query   = (in_i.req_type == REQ_QUERY);
  assign full_now   = (32'(doc_cnt_q) >= MAX_DOCS);
  // a type switch mid-vector restarts at position zero
  assign pos_eff    = ((pos_q != '0) && (kind_q != is_query)) ? '0 : pos_q;
  assign in_range   = (32'(pos_eff) < VEC_LEN);
  assign pos_nxt    = in_range ? pos_eff + PPW'(1) : pos_eff;
  assign need_fill  = (32'(pos_nxt) < VEC_LEN) && (is_query || !full_now);
  assign fill_end   = (32'(pos_q) == VEC_LEN - 1);
  assign out_free   = !out_valid_q || res_o.ready;
  // the output register takes a new item only when it is free
  assign out_load   = out_free && ((state_q == T_RES) || (state_q == T_EMIT));
  assign emit_last  = (KW'(emit_q) == k_q - KW'(1));

  // out-of-range top_k folds to the nearest legal value
  assign k_clamp = (top_k_q == 4'd0) ? KW'(1) :
                   ((32'(top_k_q) > MAX_TOP_K) ? KW'(MAX_TOP_K) : KW'(top_k_q));

  // ram write port: streaming element or zero-fill sweep
  always_comb begin
    if (state_q == T_FILL) begin
      qram_we    = kind_q;
      dram_we    = !kind_q;
      qram_waddr = pos_q[IW-1:0];
      dram_waddr = wbase_q + DAW'(pos_q);
      ram_wdata  = '0;
    end else begin
      qram_we    = acc && is_query && in_range;
      dram_we    = acc && (in_i.req_type == REQ_DOC) && !full_now && in_range;
      qram_waddr = pos_eff[IW-1:0];
      dram_waddr = wbase_q + DAW'(pos_eff);
      ram_wdata  = in_i.value;
    end
  end

  assign dram_raddr = rbase_q + DAW'(rd_idx);
  assign sc_start   = (state_q == T_START);

  vs_ram #(.WIDTH(16), .DEPTH(VEC_LEN)) u_qram (
    .clk_i   (clk_i),
    .we_i    (qram_we),
    .waddr_i (qram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx),
    .rdata_o (q_rdata)
  );

  vs_ram #(.WIDTH(16), .DEPTH(MAX_DOCS * VEC_LEN)) u_dram (
    .clk_i   (clk_i),
    .we_i    (dram_we),
    .waddr_i (dram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (dram_raddr),
    .rdata_o (d_rdata)
  );

  vs_score #(.VEC_LEN(VEC_LEN)) u_score (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sc_start),
    .q_i      (q_rdata),
    .d_i      (d_rdata),
    .rd_idx_o (rd_idx),
    .res_o    (sc_res)
  );

  // strict greater-than against the sorted list; hits form a run to the tail
  always_comb begin
    for (int j = 0; j < MAX_TOP_K; j++) begin
      gt[j] = (j < 32'(k_q)) && (sc_res.score > best_score_q[j]);
    end
  end

  // result valid: set on a load, cleared when the item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      pos_q       <= '0;
      kind_q      <= 1'b0;
      doc_cnt_q   <= '0;
      doc_q       <= '0;
      wbase_q     <= '0;
      rbase_q     <= '0;
      top_k_q     <= TOP_K_RST;
      k_q         <= KW'(1);
      emit_q      <= '0;
      for (int j = 0; j < MAX_TOP_K; j++) begin
        best_score_q[j] <= SCORE_MIN;
        best_idx_q[j]   <= '0;
        best_val_q[j]   <= 1'b0;
      end
    end else begin
      if (top_k_we_i) begin
        top_k_q <= top_k_i;
      end

      case (state_q)
        T_IDLE: begin
          if (acc && in_i.req_type == REQ_CLEAR) begin
            doc_cnt_q    <= '0;
            wbase_q      <= '0;
            pos_q        <= '0;
            res_status_q <= ST_CLEARED;
            res_idx_q    <= '0;
            state_q      <= T_RES;
          end else if (acc && is_elem) begin
            kind_q <= is_query;
            if (in_i.last_element) begin
              if (need_fill) begin
                pos_q   <= pos_nxt;
                state_q <= T_FILL;
              end else begin
                pos_q <= '0;
                if (is_query) begin
                  state_q <= T_QINIT;
                end else begin
                  state_q      <= T_RES;
                  res_status_q <= full_now ? ST_FULL : ST_STORED;
                  res_idx_q    <= full_now ? 7'd0 : 7'(doc_cnt_q);
                  if (!full_now) begin
                    doc_cnt_q <= doc_cnt_q + DCW'(1);
                    wbase_q   <= wbase_q + DAW'(VEC_LEN);
                  end
                end
              end
            end else begin
              pos_q <= pos_nxt;
            end
          end
        end
        T_FILL: begin
          if (fill_end) begin
            pos_q <= '0;
            if (kind_q) begin
              state_q <= T_QINIT;
            end else begin
              // a full store never fills, so this document is stored
              state_q      <= T_RES;
              res_status_q <= ST_STORED;
              res_idx_q    <= 7'(doc_cnt_q);
              doc_cnt_q    <= doc_cnt_q + DCW'(1);
              wbase_q      <= wbase_q + DAW'(VEC_LEN);
            end
          end else begin
            pos_q <= pos_q + PPW'(1);
          end
        end
        T_RES: begin
          if (out_free) begin
            out_status_q <= res_status_q;
            out_rank_q   <= '0;
            out_idx_q    <= res_idx_q;
            out_found_q  <= 1'b0;
            out_score_q  <= '0;
            out_last_q   <= 1'b1;
            state_q      <= T_IDLE;
          end
        end
        T_QINIT: begin
          k_q     <= k_clamp;
          doc_q   <= '0;
          rbase_q <= '0;
          emit_q  <= '0;
          for (int j = 0; j < MAX_TOP_K; j++) begin
            best_score_q[j] <= SCORE_MIN;
            best_idx_q[j]   <= '0;
            best_val_q[j]   <= 1'b0;
          end
          state_q <= (doc_cnt_q == '0) ? T_EMIT : T_START;
        end
        T_START: state_q <= T_WAIT;
        T_WAIT: begin
          if (sc_res.done) begin
            for (int j = 0; j < MAX_TOP_K; j++) begin
              if (gt[j]) begin
                if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
                  best_score_q[j] <= best_score_q[(j > 0) ? j - 1 : 0];
                  best_idx_q[j]   <= best_idx_q[(j > 0) ? j - 1 : 0];
                  best_val_q[j]   <= best_val_q[(j > 0) ? j - 1 : 0];
                end else begin
                  best_score_q[j] <= sc_res.score;
                  best_idx_q[j]   <= DIW'(doc_q);
                  best_val_q[j]   <= 1'b1;
                end
              end
            end
            doc_q   <= doc_q + DCW'(1);
            rbase_q <= rbase_q + DAW'(VEC_LEN);
            state_q <= (doc_q + DCW'(1) == doc_cnt_q) ? T_EMIT : T_START;
          end
        end
        T_EMIT: begin
          if (out_free) begin
            out_status_q <= ST_RESULT;
            out_rank_q   <= 3'(emit_q);
            out_found_q  <= best_val_q[emit_q];
            out_idx_q    <= best_val_q[emit_q] ? 7'(best_idx_q[emit_q]) : 7'd0;
            out_score_q  <= best_val_q[emit_q] ? best_score_q[emit_q] : SCORE_MIN;
            out_last_q   <= emit_last;
            emit_q       <= emit_q + KIW'(1);
            if (emit_last) begin
              state_q <= T_IDLE;
            end
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_status_q;
  assign res_o.rank        = out_rank_q;
  assign res_o.doc_index   = out_idx_q;
  assign res_o.found       = out_found_q;
  assign res_o.match_score = out_score_q;
  assign res_o.last        = out_last_q;

endmodule
`default_nettype wire

// ===== src/vs_checker.sv =====
// port-level checks for the vector search block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module vs_checker import vs_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_i,
  input wire logic [2:0]  rank_i,
  input wire logic [6:0]  doc_index_i,
  input wire logic        found_i,
  input wire logic [15:0] match_score_i,
  input wire logic        last_i
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(match_score_i)
      && $stable(doc_index_i) && $stable(status_i) && $stable(last_i))
    else $error("stalled result changed");

  // store, full and clear answers are single items
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_RESULT |-> last_i && rank_i == 3'd0 && !found_i)
    else $error("non-search result malformed");

  // an empty slot reports index zero and score minus one
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_RESULT && !found_i
      |-> doc_index_i == 7'd0 && match_score_i == 16'h8000)
    else $error("empty slot malformed");

  // a found slot never carries minus one
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_RESULT && found_i |-> match_score_i != 16'h8000)
    else $error("found slot has minimum score");

endmodule

bind cosine_topk_vector_search vs_checker u_vs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .status_i      (res_o.status),
  .rank_i        (res_o.rank),
  .doc_index_i   (res_o.doc_index),
  .found_i       (res_o.found),
  .match_score_i (res_o.match_score),
  .last_i        (res_o.last)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the cosine top-k vector search block
`timescale 1ns / 1ps
module testbench;
  import vs_pkg::*;

  localparam int          NUM_DOCS    = MAX_DOCS_DEF;
  localparam int          VEC_LEN     = VEC_LEN_DEF;
  localparam int          LIST_DEPTH  = MAX_TOP_K_DEF;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam int          CYCLE_LIMIT = 3000000;
  localparam int          SETTLE      = VEC_LEN + 40;

  typedef struct {
    logic [1:0]         status;
    logic [2:0]         rank;
    logic [6:0]         doc_index;
    logic               found;
    logic signed [15:0] score;
    logic               last;
  } match_t;

  // predicts the block from accepted items and checks each result in order
  class search_scoreboard;
    shortint    docs[NUM_DOCS][VEC_LEN];
    shortint    query_vec[VEC_LEN];
    int         doc_count;
    int         elem_pos;
    logic [1:0] kind;
    logic [3:0] top_k;
    match_t     expected_q[$];
    int         errors;

    function new();
      doc_count = 0;
      elem_pos  = 0;
      kind      = REQ_DOC;
      top_k     = TOP_K_RST;
      errors    = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push(logic [1:0] st, int rk, int idx, logic fnd, int sc, logic lst);
      match_t m;
      m.status = st; m.rank = rk[2:0]; m.doc_index = idx[6:0];
      m.found = fnd; m.score = sc[15:0]; m.last = lst;
      expected_q.push_back(m);
    endfunction

    function longint root_floor(longint x);
      longint lo, hi, mid;
      lo = 0; hi = 1 << 21;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (mid * mid <= x) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function int cos_score(int d);
      longint dot, nq, nd, s;
      dot = 0; nq = 0; nd = 0;
      for (int i = 0; i < VEC_LEN; i++) begin
        dot += longint'(query_vec[i]) * longint'(docs[d][i]);
        nq  += longint'(query_vec[i]) * longint'(query_vec[i]);
        nd  += longint'(docs[d][i]) * longint'(docs[d][i]);
      end
      if (nq == 0 || nd == 0) return 0;
      s = (dot * 32768) / (root_floor(nq) * root_floor(nd));
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      return int'(s);
    endfunction

    function void note_input(logic [1:0] req, logic signed [15:0] v, logic fin);
      bit full;
      int k;
      int bs[LIST_DEPTH];
      int bi[LIST_DEPTH];
      bit bv[LIST_DEPTH];
      int s;
      full = doc_count >= NUM_DOCS;
      if (req == REQ_UNUSED) return;
      if (req == REQ_CLEAR) begin
        doc_count = 0;
        elem_pos  = 0;
        push(ST_CLEARED, 0, 0, 0, 0, 1);
        return;
      end
      if (elem_pos != 0 && kind != req) elem_pos = 0;
      kind = req;
      if (elem_pos < VEC_LEN) begin
        if (req == REQ_QUERY) query_vec[elem_pos] = v;
        else if (!full) docs[doc_count][elem_pos] = v;
        elem_pos++;
      end
      if (!fin) return;
      for (int j = elem_pos; j < VEC_LEN; j++) begin
        if (req == REQ_QUERY) query_vec[j] = 0;
        else if (!full) docs[doc_count][j] = 0;
      end
      elem_pos = 0;
      if (req == REQ_DOC) begin
        if (full) push(ST_FULL, 0, 0, 0, 0, 1);
        else begin
          push(ST_STORED, 0, doc_count, 0, 0, 1);
          doc_count++;
        end
        return;
      end
      // query: strict greater-than insertion keeps the earlier document on a tie
      k = int'(top_k);
      if (k < 1) k = 1;
      if (k > LIST_DEPTH) k = LIST_DEPTH;
      for (int j = 0; j < LIST_DEPTH; j++) begin
        bs[j] = -32768; bi[j] = 0; bv[j] = 0;
      end
      for (int d = 0; d < doc_count; d++) begin
        s = cos_score(d);
        for (int j = 0; j < k; j++) begin
          if (s > bs[j]) begin
            for (int m = k - 1; m > j; m--) begin
              bs[m] = bs[m-1]; bi[m] = bi[m-1]; bv[m] = bv[m-1];
            end
            bs[j] = s; bi[j] = d; bv[j] = 1;
            break;
          end
        end
      end
      for (int j = 0; j < k; j++) begin
        if (bv[j]) push(ST_RESULT, j, bi[j], 1, bs[j], j == k - 1);
        else push(ST_RESULT, j, 0, 0, -32768, j == k - 1);
      end
    endfunction

    function void check(match_t got);
      match_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d rank %0d doc_index %0d",
               got.status, got.rank, got.doc_index);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status); errors++;
      end
      if (got.rank !== e.rank) begin
        $error("rank: expected %0d, got %0d", e.rank, got.rank); errors++;
      end
      if (got.doc_index !== e.doc_index) begin
        $error("doc_index: expected %0d, got %0d", e.doc_index, got.doc_index); errors++;
      end
      if (got.found !== e.found) begin
        $error("found: expected %0d, got %0d", e.found, got.found); errors++;
      end
      if (got.score !== e.score) begin
        $error("match_score: expected %0d, got %0d", e.score, got.score); errors++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       top_k_we_i = 0;
  logic [3:0] top_k_i = TOP_K_RST;

  vs_in_if  in_ch();
  vs_out_if res_ch();

  cosine_topk_vector_search dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .res_o      (res_ch),
    .top_k_we_i (top_k_we_i),
    .top_k_i    (top_k_i)
  );

  search_scoreboard sb = new();

  always #4 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 0;
    in_ch.req_type = REQ_DOC;
    in_ch.value = 0;
    in_ch.last_element = 0;
    res_ch.ready = 0;
  end

  // cycle counter guards against a hung block
  int cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** cosine_topk_vector_search: FAILED **");
      $finish;
    end
  end

  // result side: checks accepted items and stalls on its own pattern
  int hold_cycles = 0;
  int stall_mode  = 0;
  int mode_left   = 0;
  int phase_cnt   = 0;
  always @(posedge clk_i) begin
    match_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got.status = res_ch.status; got.rank = res_ch.rank;
      got.doc_index = res_ch.doc_index; got.found = res_ch.found;
      got.score = res_ch.match_score; got.last = res_ch.last;
      sb.check(got);
    end
    phase_cnt <= phase_cnt + 1;
    if (hold_cycles > 0) begin
      // long hold-off so the block backs up into its input
      hold_cycles <= hold_cycles - 1;
      res_ch.ready <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(5, 60);
      end else mode_left <= mode_left - 1;
      case (stall_mode)
        0: res_ch.ready <= 1;
        1: res_ch.ready <= ($urandom_range(0, 1) == 1);
        default: res_ch.ready <= (phase_cnt % 3 != 0);
      endcase
    end
  end

  // request side: bursts of random length with random gaps
  int burst_left = 0;
  int vec_items  = 0;

  task automatic send_item(logic [1:0] req, logic signed [15:0] v, logic fin);
    in_ch.valid        <= 1;
    in_ch.req_type     <= req;
    in_ch.value        <= v;
    in_ch.last_element <= fin;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(req, v, fin);
    if (burst_left == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(10, 40);
    end else burst_left--;
  endtask

  function automatic logic signed [15:0] pick_value(int flavor);
    case (flavor)
      0: return 16'($urandom_range(0, 65535));
      1: return $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
      default: return $urandom_range(0, 1) ? SCORE_MAX : SCORE_MIN;
    endcase
  endfunction

  // one vector of n elements, the last one flagged
  task automatic send_vector(logic [1:0] req, int n, int flavor);
    for (int i = 0; i < n; i++) begin
      send_item(req, pick_value(flavor), i == n - 1);
      vec_items++;
    end
  endtask

  task automatic send_const(logic [1:0] req, int n, logic signed [15:0] v);
    for (int i = 0; i < n; i++) send_item(req, v, i == n - 1);
  endtask

  // drain every expected result, then stay quiet a while
  task automatic wait_idle();
    in_ch.valid <= 0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_top_k(logic [3:0] k);
    wait_idle();
    top_k_we_i <= 1;
    top_k_i    <= k;
    @(posedge clk_i);
    top_k_we_i <= 0;
    sb.top_k = k;
  endtask

  initial begin
    int op;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);

    // directed part at the reset top_k
    send_const(REQ_QUERY, 2, 16'sd100);          // query with an empty store
    send_const(REQ_DOC, 3, SCORE_MAX);            // doc 0 max in its first three elements
    send_const(REQ_DOC, 2, SCORE_MIN);            // doc 1 min in its first two elements
    send_const(REQ_DOC, 1, 16'sd0);               // doc 2 zero norm
    send_const(REQ_DOC, 1, -16'sd1000);           // doc 3 exact opposite of query below
    send_const(REQ_QUERY, 1, 16'sd1000);          // minus one never enters the list
    send_const(REQ_QUERY, 3, SCORE_MAX);          // query in the same direction as doc 0
    send_item(REQ_UNUSED, 16'sd5, 1);             // ignored request
    send_item(REQ_DOC, 16'sd7, 0);                // doc abandoned by a type switch
    send_item(REQ_QUERY, 16'sd0, 1);              // zero query scores all zero
    send_item(REQ_QUERY, 16'sd9, 0);              // query abandoned by a type switch
    send_item(REQ_DOC, 16'sd300, 1);
    send_item(REQ_CLEAR, 16'sd0, 0);

    // store full: fill every slot, then one more
    set_top_k(4'd1);
    for (int i = 0; i <= NUM_DOCS; i++) send_item(REQ_DOC, pick_value(0), 1);
    send_item(REQ_CLEAR, 16'sd0, 1);

    set_top_k(4'd8);
    send_vector(REQ_DOC, 3, 1);
    send_vector(REQ_DOC, VEC_LEN + 2, 0);         // elements past the end are dropped
    send_vector(REQ_QUERY, 3, 1);
    set_top_k(4'd0);
    send_vector(REQ_QUERY, 2, 1);
    set_top_k(4'd15);
    send_vector(REQ_QUERY, 2, 0);

    // random part
    vec_items = 0;
    while (vec_items < 130) begin
      if (sb.doc_count > 10) send_item(REQ_CLEAR, pick_value(0), 1'($urandom_range(0, 1)));
      op = $urandom_range(0, 99);
      if (op < 45) send_vector(REQ_DOC, $urandom_range(1, 6), $urandom_range(0, 2));
      else if (op < 70) send_vector(REQ_QUERY, $urandom_range(1, 6), $urandom_range(0, 2));
      else if (op < 75) send_item(REQ_CLEAR, pick_value(0), 1'($urandom_range(0, 1)));
      else if (op < 80) send_item(REQ_UNUSED, pick_value(0), 1'($urandom_range(0, 1)));
      else if (op < 94) begin
        // broken vector: one non-final element of a random type
        send_item(2'($urandom_range(0, 1)), pick_value(0), 0);
        vec_items++;
      end else if (op < 97) set_top_k(4'($urandom_range(0, 15)));
      else begin
        // back-pressure: long hold while documents keep coming
        hold_cycles = 700;
        for (int i = 0; i < 4; i++) send_vector(REQ_DOC, $urandom_range(1, 3), 0);
        // then pause until everything is back
        wait_idle();
      end
    end
    if (sb.doc_count == 0) send_vector(REQ_DOC, 2, 0);
    hold_cycles = 700;
    send_vector(REQ_DOC, 2, 1);
    send_vector(REQ_DOC, 2, 1);
    send_vector(REQ_QUERY, 2, 1);
    set_top_k(4'd3);
    send_vector(REQ_QUERY, 4, 0);

    wait_idle();
    if (sb.errors == 0) $display("** cosine_topk_vector_search: PASSED **");
    else $display("** cosine_topk_vector_search: FAILED **");
    $finish;
  end

endmodule
